// ===== hdl/sgmpc_pkg.sv =====
// Shared constants and register codes for the SGM path-cost unit.
`timescale 1ns / 1ps
`default_nettype none

package sgmpc_pkg;

  // Defaults for the top-level parameters.
  localparam int MaxDispDefault   = 64;
  localparam int CostWidthDefault = 16;

  // Fixed field widths.
  localparam int NumDispW  = 7;
  localparam int PenaltyW  = 16;
  localparam int DispOutW  = 6;
  localparam int ApbDataW  = 32;
  localparam int ApbAddrW  = 4;
  localparam int RegIndexW = 2;

  // Register indexes (byte address = 4 * index).
  localparam logic [RegIndexW-1:0] RegNumDisp  = 2'd0;
  localparam logic [RegIndexW-1:0] RegSmallPen = 2'd1;
  localparam logic [RegIndexW-1:0] RegLargePen = 2'd2;

  // Register reset values.
  localparam logic [NumDispW-1:0] NumDispReset  = 7'd64;
  localparam logic [PenaltyW-1:0] SmallPenReset = 16'd10;
  localparam logic [PenaltyW-1:0] LargePenReset = 16'd120;

endpackage

`default_nettype wire

// ===== hdl/sgmpc_stream_if.sv =====
// Valid/ready stream interfaces for the cost input and the path-cost output.
`timescale 1ns / 1ps
`default_nettype none

interface sgmpc_in_if #(
  parameter int COST_WIDTH = sgmpc_pkg::CostWidthDefault
) ();
  logic                  valid;
  logic                  ready;
  logic [COST_WIDTH-1:0] data_cost;
  logic                  path_start;

  modport source (output valid, output data_cost, output path_start, input ready);
  modport sink   (input valid, input data_cost, input path_start, output ready);
endinterface

interface sgmpc_out_if #(
  parameter int COST_WIDTH = sgmpc_pkg::CostWidthDefault
) ();
  logic                          valid;
  logic                          ready;
  logic [COST_WIDTH:0]           path_cost;
  logic [sgmpc_pkg::DispOutW-1:0] disparity;
  logic                          last_of_pixel;

  modport source (output valid, output path_cost, output disparity, output last_of_pixel,
                  input ready);
  modport sink   (input valid, input path_cost, input disparity, input last_of_pixel,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/sgm_path_cost_recurrence_unit.sv =====
// Top level of the semi-global matching path-cost recurrence unit.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one matching cost per cycle on cost_i, disparity 0 first, and
// returns one path cost per transfer on cost_o, in the cycle after the input
// transfer at the earliest. The sustained rate is one item per clock while
// cost_o is ready: the previous pixel's cost vector sits in a ping-pong memory
// of two banks of MAX_DISPARITIES words, each bank rounded up to a power of
// two, with one write and one read port, and the three neighbor costs are held
// in a sliding window that is refilled by a single prefetch read per item
// (costs d-1, d and d+1 are in registers when item d arrives). At the end of
// a pixel the first two entries of the new previous vector come from bypass
// registers, so pixels also follow back to back. The output side has a result
// register and a skid register, so an input transfer is still taken in a cycle
// in which a finished result waits. Writing num_disparities restarts the
// stream: the next pixel is treated as a path start. Penalty writes take
// effect on the next item. Configuration must be written only while the unit
// is idle; the unit does not enforce this. No clearing pass runs after reset.
module sgm_path_cost_recurrence_unit #(
  parameter int MAX_DISPARITIES = sgmpc_pkg::MaxDispDefault,
  parameter int COST_WIDTH      = sgmpc_pkg::CostWidthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  sgmpc_in_if.sink                            cost_i,
  sgmpc_out_if.source                         cost_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sgmpc_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [sgmpc_pkg::ApbDataW-1:0] pwdata,
  output logic      [sgmpc_pkg::ApbDataW-1:0] prdata,
  output logic                                pready
);
  import sgmpc_pkg::*;

  // Disparity index width, count width, path-cost width, and the width at
  // which all sums are formed without overflow.
  localparam int DW = $clog2(MAX_DISPARITIES);
  localparam int NW = DW + 1;
  localparam int PW = COST_WIDTH + 1;
  localparam int SW = ((PW > PenaltyW) ? PW : PenaltyW) + 2;
  localparam int MemDepth = 2 * (1 << DW);

  // ---------------------------------------------------------------------------
  // Configuration registers on the APB port.
  // ---------------------------------------------------------------------------
  logic [NumDispW-1:0]  num_disp_q;
  logic [PenaltyW-1:0]  small_pen_q;
  logic [PenaltyW-1:0]  large_pen_q;
  logic                 cfg_wr;
  logic [RegIndexW-1:0] cfg_idx;
  logic                 restart;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ApbAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && (cfg_idx == RegNumDisp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_disp_q  <= NumDispReset;
      small_pen_q <= SmallPenReset;
      large_pen_q <= LargePenReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegNumDisp:  num_disp_q  <= pwdata[NumDispW-1:0];
        RegSmallPen: small_pen_q <= pwdata[PenaltyW-1:0];
        RegLargePen: large_pen_q <= pwdata[PenaltyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegNumDisp:  prdata = ApbDataW'(num_disp_q);
      RegSmallPen: prdata = ApbDataW'(small_pen_q);
      RegLargePen: prdata = ApbDataW'(large_pen_q);
      default:     prdata = '0;
    endcase
  end

  // The disparity count in use is the register clamped to [2, MAX_DISPARITIES].
  logic [NW-1:0] n_act;

  always_comb begin
    if (num_disp_q < NumDispW'(2)) begin
      n_act = NW'(2);
    end else if (int'(num_disp_q) > MAX_DISPARITIES) begin
      n_act = NW'(MAX_DISPARITIES);
    end else begin
      n_act = NW'(num_disp_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: result register plus skid register.
  // ---------------------------------------------------------------------------
  logic          out_valid_q, skid_valid_q;
  logic [PW-1:0] out_cost_q, skid_cost_q;
  logic [DispOutW-1:0] out_disp_q, skid_disp_q;
  logic          out_last_q, skid_last_q;
  logic          in_xfer, out_xfer;

  assign cost_i.ready = !skid_valid_q;
  assign in_xfer      = cost_i.valid && !skid_valid_q;
  assign out_xfer     = out_valid_q && cost_o.ready;

  assign cost_o.valid         = out_valid_q;
  assign cost_o.path_cost     = out_cost_q;
  assign cost_o.disparity     = out_disp_q;
  assign cost_o.last_of_pixel = out_last_q;

  // ---------------------------------------------------------------------------
  // Recurrence state.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] disp_q;
  logic          bank_q;
  logic [PW-1:0] prev_min_q;
  logic [PW-1:0] run_min_q;
  logic          start_q;
  logic          prev_valid_q;

  // Sliding window over the previous vector: win_lo_q is cost d-1, win_mid_q is
  // cost d, rd_q is cost d+1 (memory read register).
  logic [PW-1:0] win_lo_q, win_mid_q, rd_q;
  // First two costs of the current pixel, for the pixel turnover.
  logic [PW-1:0] cur0_q, cur1_q;

  logic [PW-1:0] mem_q [MemDepth];

  logic          is_first, is_last, eff_start;
  logic [PW-1:0] nb, cost, cur1_now, run_min_new;
  logic [SW-1:0] nb_sum, pm_sum, best, full_sum;
  logic [DW:0]   disp_plus2;
  logic [DW:0]   wr_addr, rd_addr;
  logic [DW+DispOutW-1:0] disp_wide;

  assign is_first  = (disp_q == '0);
  assign is_last   = ({1'b0, disp_q} == (n_act - NW'(1)));
  assign eff_start = is_first ? cost_i.path_start : start_q;

  always_comb begin
    priority if (is_first) begin
      nb = rd_q;
    end else if (is_last) begin
      nb = win_lo_q;
    end else begin
      nb = (win_lo_q < rd_q) ? win_lo_q : rd_q;
    end
  end

  always_comb begin
    nb_sum = SW'(nb) + SW'(small_pen_q);
    pm_sum = SW'(prev_min_q) + SW'(large_pen_q);
    best   = SW'(win_mid_q);
    if (nb_sum < best) begin
      best = nb_sum;
    end
    if (pm_sum < best) begin
      best = pm_sum;
    end
    // Every previous cost is at least the previous minimum, so this never wraps.
    full_sum = SW'(cost_i.data_cost) + best - SW'(prev_min_q);
    if (eff_start || !prev_valid_q) begin
      cost = PW'(cost_i.data_cost);
    end else begin
      cost = full_sum[PW-1:0];
    end
  end

  assign run_min_new = (cost < run_min_q) ? cost : run_min_q;
  assign cur1_now    = (disp_q == DW'(1)) ? cost : cur1_q;
  assign disp_plus2  = {1'b0, disp_q} + (DW+1)'(2);
  assign wr_addr     = {bank_q, disp_q};
  assign rd_addr     = {!bank_q, disp_plus2[DW-1:0]};
  assign disp_wide   = {{DispOutW{1'b0}}, disp_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q       <= '0;
      bank_q       <= 1'b0;
      prev_min_q   <= '0;
      run_min_q    <= '1;
      start_q      <= 1'b1;
      prev_valid_q <= 1'b0;
    end else if (restart) begin
      disp_q       <= '0;
      run_min_q    <= '1;
      start_q      <= 1'b1;
      prev_valid_q <= 1'b0;
    end else if (in_xfer) begin
      start_q <= eff_start;
      if (is_last) begin
        disp_q       <= '0;
        bank_q       <= !bank_q;
        prev_min_q   <= run_min_new;
        run_min_q    <= '1;
        prev_valid_q <= 1'b1;
      end else begin
        disp_q    <= disp_q + DW'(1);
        run_min_q <= run_min_new;
      end
    end
  end

  // Cost memory and the window that feeds from it.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mem_q[wr_addr] <= cost;
      if (is_first) begin
        cur0_q <= cost;
      end
      cur1_q <= cur1_now;
      if (is_last) begin
        // The vector just finished becomes the previous one.
        win_mid_q <= cur0_q;
        rd_q      <= cur1_now;
      end else begin
        win_lo_q  <= win_mid_q;
        win_mid_q <= rd_q;
        rd_q      <= mem_q[rd_addr];
      end
    end
  end

  // Output and skid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_xfer) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid_q || cost_o.ready) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_cost_q <= skid_cost_q;
        out_disp_q <= skid_disp_q;
        out_last_q <= skid_last_q;
      end
    end else if (in_xfer) begin
      if (!out_valid_q || cost_o.ready) begin
        out_cost_q <= cost;
        out_disp_q <= disp_wide[DispOutW-1:0];
        out_last_q <= is_last;
      end else begin
        skid_cost_q <= cost;
        skid_disp_q <= disp_wide[DispOutW-1:0];
        skid_last_q <= is_last;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sgmpc_checker.sv =====
// Port-level assertions for the SGM path-cost unit and their bind statement.
`timescale 1ns / 1ps
`default_nettype none

module sgmpc_checker #(
  parameter int COST_WIDTH = sgmpc_pkg::CostWidthDefault
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [COST_WIDTH:0]            path_cost_i,
  input wire logic [sgmpc_pkg::DispOutW-1:0] disparity_i,
  input wire logic                           last_of_pixel_i,
  input wire logic                           psel_i,
  input wire logic                           penable_i,
  input wire logic                           pwrite_i,
  input wire logic                           pready_i,
  input wire logic [sgmpc_pkg::ApbAddrW-1:0] paddr_i
);
  import sgmpc_pkg::*;

  logic                in_xfer, out_xfer, restart;
  logic                seen_q, last_q;
  logic [DispOutW-1:0] disp_q, disp_next;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_xfer  = out_valid_i && out_ready_i;
  assign restart   = psel_i && penable_i && pwrite_i && pready_i &&
                     (paddr_i[ApbAddrW-1:2] == RegNumDisp);
  assign disp_next = last_q ? '0 : disp_q + DispOutW'(1);

  // Track the disparity of the last transferred result to check the order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      last_q <= 1'b0;
      disp_q <= '0;
    end else if (restart) begin
      seen_q <= 1'b0;
    end else if (out_xfer) begin
      seen_q <= 1'b1;
      last_q <= last_of_pixel_i;
      disp_q <= disparity_i;
    end
  end

  // A stalled result is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(path_cost_i) &&
                                    $stable(disparity_i) && $stable(last_of_pixel_i))
    else $error("stalled result changed");

  // After every accepted item the output holds a valid result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_i)
    else $error("accepted item did not reach the output register");

  // With the output register empty the skid stage is empty too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while no result is pending");

  // Disparities count up and restart at zero after the last of a pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && seen_q && !restart |-> disparity_i == disp_next)
    else $error("disparity out of sequence");

  // The path cost never reaches the all-ones code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> path_cost_i != '1)
    else $error("path cost out of range");

endmodule

bind sgm_path_cost_recurrence_unit sgmpc_checker #(
  .COST_WIDTH(COST_WIDTH)
) u_sgmpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (cost_i.valid),
  .in_ready_i      (cost_i.ready),
  .out_valid_i     (cost_o.valid),
  .out_ready_i     (cost_o.ready),
  .path_cost_i     (cost_o.path_cost),
  .disparity_i     (cost_o.disparity),
  .last_of_pixel_i (cost_o.last_of_pixel),
  .psel_i          (psel),
  .penable_i       (penable),
  .pwrite_i        (pwrite),
  .pready_i        (pready),
  .paddr_i         (paddr)
);

`default_nettype wire

// ===== tb/tb_sgm_path_cost_recurrence_unit.sv =====
// Self-checking testbench for the SGM path-cost recurrence unit.
`timescale 1ns / 1ps

module tb_sgm_path_cost_recurrence_unit;
  import sgmpc_pkg::*;

  localparam int CostW = CostWidthDefault;
  localparam int PathW = CostWidthDefault + 1;
  localparam int MaxDisp = MaxDispDefault;

  // Address slot 3 has no register behind it; writes there must be dropped.
  localparam logic [RegIndexW-1:0] RegUnused = 2'd3;

  // Random part size, receiver hold-off length, quiet-cycle limit and drain tail.
  localparam int unsigned RandomItems = 320;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned TailCycles = 16;

  typedef struct packed {
    logic [PathW-1:0]    path_cost;
    logic [DispOutW-1:0] disparity;
    logic                last_of_pixel;
  } path_cost_t;

  logic clk_i;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  sgmpc_in_if  #(.COST_WIDTH(CostW)) cost_in_bus ();
  sgmpc_out_if #(.COST_WIDTH(CostW)) cost_out_bus ();

  sgm_path_cost_recurrence_unit #(
    .MAX_DISPARITIES(MaxDisp),
    .COST_WIDTH     (CostW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cost_i (cost_in_bus),
    .cost_o (cost_out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Path costs predicted for accepted inputs, oldest first.
  path_cost_t pending_path_costs[$];
  path_cost_t oldest_cost;

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  // When set, neither the sender nor the receiver inserts random idle cycles.
  bit steady_link;
  // A nonzero value asks the receiver to hold off for that many cycles.
  int unsigned hold_request;
  int unsigned hold_left;

  // Predictor state: the two cost vectors of the ping-pong pair, the pixel
  // bookkeeping, and a shadow copy of the three configuration registers.
  logic [PathW-1:0]    path_mem[2][MaxDisp];
  logic                write_bank;
  int unsigned         disp_index;
  logic [PathW-1:0]    prev_min;
  logic [PathW-1:0]    run_min;
  logic                pixel_starts_path;
  logic                have_prev_pixel;
  logic [NumDispW-1:0] num_disp_reg;
  logic [PenaltyW-1:0] small_pen_reg;
  logic [PenaltyW-1:0] large_pen_reg;

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Disparities per pixel actually in use: the register is clamped to the
  // range from 2 to the memory depth.
  function automatic int unsigned active_disparities();
    if (num_disp_reg < 2) begin
      return 2;
    end
    if (num_disp_reg > MaxDisp) begin
      return MaxDisp;
    end
    return num_disp_reg;
  endfunction

  // A new disparity count restarts the stream, so the next pixel has no
  // predecessor and the minimum search starts over.
  function automatic void restart_path();
    disp_index = 0;
    have_prev_pixel = 1'b0;
    pixel_starts_path = 1'b1;
    run_min = '1;
  endfunction

  function automatic void set_register(input logic [RegIndexW-1:0] idx,
                                       input logic [ApbDataW-1:0] value);
    case (idx)
      RegNumDisp: begin
        num_disp_reg = value[NumDispW-1:0];
        restart_path();
      end
      RegSmallPen: begin
        small_pen_reg = value[PenaltyW-1:0];
      end
      RegLargePen: begin
        large_pen_reg = value[PenaltyW-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Works out the path cost for one accepted data cost and advances the
  // predictor state exactly as the unit is expected to.
  function automatic path_cost_t predict_path_cost(input logic [CostW-1:0] data,
                                                   input logic start);
    int unsigned n;
    int unsigned d;
    logic        read_bank;
    logic [31:0] best;
    logic [31:0] neighbor;
    logic [31:0] cand;
    logic [31:0] total;
    path_cost_t  result;

    n = active_disparities();
    d = (disp_index >= n) ? 0 : disp_index;
    read_bank = ~write_bank;
    if (d == 0) begin
      pixel_starts_path = start;
    end

    if (pixel_starts_path || !have_prev_pixel) begin
      total = 32'(data);
    end else begin
      best = 32'(path_mem[read_bank][d]);
      // Only the neighbor that exists is used at either end of the vector.
      if (d == 0) begin
        neighbor = 32'(path_mem[read_bank][1]);
      end else if (d == n - 1) begin
        neighbor = 32'(path_mem[read_bank][d-1]);
      end else begin
        neighbor = 32'(path_mem[read_bank][d-1]);
        if (path_mem[read_bank][d+1] < neighbor) begin
          neighbor = 32'(path_mem[read_bank][d+1]);
        end
      end
      cand = neighbor + 32'(small_pen_reg);
      if (cand < best) begin
        best = cand;
      end
      cand = 32'(prev_min) + 32'(large_pen_reg);
      if (cand < best) begin
        best = cand;
      end
      total = 32'(data) + best - 32'(prev_min);
    end

    result.path_cost = total[PathW-1:0];
    result.disparity = d[DispOutW-1:0];
    result.last_of_pixel = (d == n - 1);

    path_mem[write_bank][d] = result.path_cost;
    if (result.path_cost < run_min) begin
      run_min = result.path_cost;
    end

    if (result.last_of_pixel) begin
      prev_min = run_min;
      run_min = '1;
      write_bank = ~write_bank;
      have_prev_pixel = 1'b1;
      disp_index = 0;
    end else begin
      disp_index = d + 1;
    end
    return result;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  // A setup cycle, then an access cycle; the register takes the value at the
  // edge that completes the access. psel then stays low at the end of the task
  // so that it is never lowered and raised in the same step.
  task automatic apb_write(input logic [RegIndexW-1:0] idx, input logic [ApbDataW-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    set_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [RegIndexW-1:0] idx,
                                input logic [ApbDataW-1:0] want, input string reg_name);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("%s: expected %0d, got %0d", reg_name, want, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Cost stream sender
  // ---------------------------------------------------------------------------

  // Offers one data cost and waits for its transfer. Valid stays high after a
  // transfer; it is only lowered when the sender idles or the stream drains.
  task automatic send_cost(input logic [CostW-1:0] data, input logic start);
    if (!steady_link && $urandom_range(0, 99) < 16) begin
      cost_in_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 16);
    end
    cost_in_bus.valid <= 1'b1;
    cost_in_bus.data_cost <= data;
    cost_in_bus.path_start <= start;
    do @(posedge clk_i); while (!cost_in_bus.ready);
    pending_path_costs.insert(pending_path_costs.size(), predict_path_cost(data, start));
    items_sent++;
  endtask

  // Lets every predicted path cost arrive, then waits out the drain tail so that
  // no work is left in flight before the configuration is touched.
  task automatic wait_for_idle();
    cost_in_bus.valid <= 1'b0;
    while (pending_path_costs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Costs lean toward the extremes so that wide sums and both ends of the
  // range occur often; the rest covers every bit at random.
  function automatic logic [CostW-1:0] random_cost();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return CostW'($urandom_range(0, 255));
      3: return CostW'(16'hFFFF - $urandom_range(0, 255));
      default: return CostW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [ApbDataW-1:0] random_penalty();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd65535;
      2: return 32'($urandom_range(0, 65535));
      default: return 32'($urandom_range(0, 200));
    endcase
  endfunction

  // Mostly short vectors so that many pixels pass; now and then the full
  // depth, and raw values outside the legal range that the unit must clamp.
  function automatic logic [ApbDataW-1:0] random_disparity_count();
    case ($urandom_range(0, 9))
      0: return 32'(MaxDisp);
      1: return 32'($urandom_range(MaxDisp + 1, 127));
      2: return 32'($urandom_range(0, 1));
      default: return 32'($urandom_range(2, 12));
    endcase
  endfunction

  // Sends one whole pixel. path_start only matters on disparity 0; on the
  // other disparities it is random and must be ignored. If pause_at names a
  // disparity, the stream drains there and a penalty is rewritten mid-pixel.
  task automatic send_random_pixel(input logic start, input int pause_at);
    int n;
    n = int'(active_disparities());
    for (int d = 0; d < n; d++) begin
      if (d == pause_at) begin
        wait_for_idle();
        apb_write($urandom_range(0, 1) ? RegSmallPen : RegLargePen, random_penalty());
      end
      send_cost(random_cost(), (d == 0) ? start : 1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Path cost receiver and checker
  // ---------------------------------------------------------------------------

  // Each transfer on the output is compared with the oldest prediction. The
  // ready for the next cycle is then chosen: a requested hold-off first, else
  // random idling unless the link is steady.
  always @(posedge clk_i) begin
    if (rst_ni && cost_out_bus.valid && cost_out_bus.ready) begin
      if (pending_path_costs.size() == 0) begin
        $error("path_cost: no transfer expected, got %0d at disparity %0d",
               cost_out_bus.path_cost, cost_out_bus.disparity);
        fail_count++;
      end else begin
        oldest_cost = pending_path_costs.pop_front();
        if (cost_out_bus.path_cost !== oldest_cost.path_cost) begin
          $error("path_cost: expected %0d, got %0d",
                 oldest_cost.path_cost, cost_out_bus.path_cost);
          fail_count++;
        end
        if (cost_out_bus.disparity !== oldest_cost.disparity) begin
          $error("disparity: expected %0d, got %0d",
                 oldest_cost.disparity, cost_out_bus.disparity);
          fail_count++;
        end
        if (cost_out_bus.last_of_pixel !== oldest_cost.last_of_pixel) begin
          $error("last_of_pixel: expected %0d, got %0d",
                 oldest_cost.last_of_pixel, cost_out_bus.last_of_pixel);
          fail_count++;
        end
      end
    end

    if (!rst_ni) begin
      cost_out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      cost_out_bus.ready <= 1'b0;
    end else if (hold_request != 0) begin
      hold_left = hold_request - 1;
      hold_request = 0;
      cost_out_bus.ready <= 1'b0;
    end else begin
      cost_out_bus.ready <= steady_link || ($urandom_range(0, 99) >= 16);
    end
  end

  // The run is stopped if nothing moves on either stream or on the
  // configuration port for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cost_in_bus.valid && cost_in_bus.ready) ||
          (cost_out_bus.valid && cost_out_bus.ready) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values read back, a write to the empty slot changes nothing, and
  // every register holds the extreme values written to it.
  task automatic test_register_access();
    apb_read_check(RegNumDisp, 32'(NumDispReset), "num_disparities");
    apb_read_check(RegSmallPen, 32'(SmallPenReset), "small_penalty");
    apb_read_check(RegLargePen, 32'(LargePenReset), "large_penalty");
    apb_write(RegUnused, 32'hFFFF_FFFF);
    apb_read_check(RegNumDisp, 32'(NumDispReset), "num_disparities");
    apb_read_check(RegSmallPen, 32'(SmallPenReset), "small_penalty");
    apb_read_check(RegLargePen, 32'(LargePenReset), "large_penalty");
    apb_write(RegNumDisp, 32'd127);
    apb_write(RegSmallPen, 32'd65535);
    apb_write(RegLargePen, 32'd0);
    apb_read_check(RegNumDisp, 32'd127, "num_disparities");
    apb_read_check(RegSmallPen, 32'd65535, "small_penalty");
    apb_read_check(RegLargePen, 32'd0, "large_penalty");
  endtask

  // Short vectors with hand-picked costs: the first pixel with no
  // predecessor, extreme costs and penalties, a path start in mid-stream,
  // path_start raised off disparity 0, both ends and the middle of a vector,
  // and disparity counts below the legal range.
  task automatic test_directed_corners();
    apb_write(RegNumDisp, 32'd0);
    apb_write(RegSmallPen, 32'd65535);
    apb_write(RegLargePen, 32'd65535);
    send_cost(16'd0, 1'b0);
    send_cost(16'hFFFF, 1'b0);
    send_cost(16'hFFFF, 1'b0);
    send_cost(16'd0, 1'b1);
    send_cost(16'hFFFF, 1'b0);
    send_cost(16'hFFFF, 1'b0);
    send_cost(16'd1, 1'b1);
    send_cost(16'd2, 1'b0);
    wait_for_idle();

    apb_write(RegNumDisp, 32'd3);
    apb_write(RegSmallPen, 32'd0);
    apb_write(RegLargePen, 32'd0);
    send_cost(16'd5, 1'b0);
    send_cost(16'd0, 1'b0);
    send_cost(16'd9, 1'b0);
    send_cost(16'd0, 1'b0);
    send_cost(16'hFFFF, 1'b1);
    send_cost(16'd7, 1'b0);
    send_cost(16'hFFFF, 1'b0);
    send_cost(16'hFFFF, 1'b0);
    send_cost(16'd0, 1'b0);
    wait_for_idle();

    apb_write(RegNumDisp, 32'd1);
    apb_write(RegSmallPen, 32'd7);
    apb_write(RegLargePen, 32'd65535);
    send_cost(16'd300, 1'b1);
    send_cost(16'd0, 1'b0);
    send_cost(16'd0, 1'b0);
    send_cost(16'd300, 1'b0);
    wait_for_idle();
  endtask

  // Penalties rewritten between two disparities of one pixel must apply from
  // the next item on; a disparity count written mid-pixel restarts the path.
  task automatic test_mid_pixel_writes();
    apb_write(RegNumDisp, 32'd5);
    apb_write(RegSmallPen, 32'd4);
    apb_write(RegLargePen, 32'd40);
    send_random_pixel(1'b1, -1);
    send_random_pixel(1'b0, 2);
    send_random_pixel(1'b0, 4);
    send_cost(random_cost(), 1'b0);
    send_cost(random_cost(), 1'b0);
    wait_for_idle();
    apb_write(RegNumDisp, 32'd4);
    send_random_pixel(1'b0, -1);
    send_random_pixel(1'b0, -1);
    wait_for_idle();
  endtask

  // A long stretch in which neither side idles, so the unit runs at one item
  // per clock across pixel boundaries.
  task automatic test_steady_stream();
    apb_write(RegNumDisp, 32'd8);
    apb_write(RegSmallPen, 32'd20);
    apb_write(RegLargePen, 32'd150);
    steady_link = 1'b1;
    repeat (25) send_random_pixel(1'($urandom_range(0, 9) == 0), -1);
    wait_for_idle();
    steady_link = 1'b0;
  endtask

  // The receiver stops for a long stretch while full-depth pixels keep
  // coming, so the output registers fill and the input must stall.
  task automatic test_output_hold_off();
    apb_write(RegNumDisp, 32'd127);
    apb_write(RegSmallPen, 32'd3);
    apb_write(RegLargePen, 32'd90);
    steady_link = 1'b1;
    hold_request = HoldOffCycles;
    repeat (3) send_random_pixel(1'b0, -1);
    wait_for_idle();
    steady_link = 1'b0;
  endtask

  // Random phases: each may change the disparity count and the penalties,
  // then streams a run of pixels with random costs, rare path starts and an
  // occasional mid-pixel penalty change.
  task automatic test_random_paths();
    int unsigned stop_at;
    int unsigned n_pixels;
    int          pause_at;
    stop_at = items_sent + RandomItems;
    while (items_sent < stop_at) begin
      wait_for_idle();
      if ($urandom_range(0, 2) == 0) begin
        apb_write(RegNumDisp, random_disparity_count());
      end
      if ($urandom_range(0, 1) == 0) begin
        apb_write(RegSmallPen, random_penalty());
      end
      if ($urandom_range(0, 1) == 0) begin
        apb_write(RegLargePen, random_penalty());
      end
      n_pixels = $urandom_range(2, 2 + 160 / active_disparities());
      repeat (n_pixels) begin
        pause_at = ($urandom_range(0, 9) == 0) ?
                   int'($urandom_range(1, active_disparities() - 1)) : -1;
        send_random_pixel(1'($urandom_range(0, 9) == 0), pause_at);
      end
    end
    wait_for_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cost_in_bus.valid = 1'b0;
    cost_in_bus.data_cost = '0;
    cost_in_bus.path_start = 1'b0;
    cost_out_bus.ready = 1'b0;
    fail_count = 0;
    items_sent = 0;
    quiet_cycles = 0;
    steady_link = 1'b0;
    hold_request = 0;
    hold_left = 0;

    // The predictor starts from the reset state of the unit.
    write_bank = 1'b0;
    prev_min = '0;
    num_disp_reg = NumDispReset;
    small_pen_reg = SmallPenReset;
    large_pen_reg = LargePenReset;
    restart_path();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_corners();
    test_mid_pixel_writes();
    test_steady_stream();
    test_output_hold_off();
    test_random_paths();

    wait_for_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sgmpc_pkg.sv
hdl/sgmpc_stream_if.sv
hdl/sgm_path_cost_recurrence_unit.sv
hdl/sgmpc_checker.sv
tb/tb_sgm_path_cost_recurrence_unit.sv
